### hw/rtl/mse_pkg.sv
package mse_pkg;

	// Width of one element of a set.
	localparam int VALUE_W = 32;

	typedef logic signed [VALUE_W-1:0] value_t;

endpackage

### hw/rtl/mse_if.sv
// Request channel carrying unsorted elements into the engine.
interface mse_in_if;
	import mse_pkg::*;

	logic   valid;
	logic   ready;
	value_t value;
	logic   last;

	modport source (output valid, output value, output last, input ready);
	modport sink (input valid, input value, input last, output ready);
endinterface

// Request channel carrying sorted elements out of the engine.
interface mse_out_if;
	import mse_pkg::*;

	logic   valid;
	logic   ready;
	value_t value_res;
	logic   last_res;
	logic   dropped;

	modport source (output valid, output value_res, output last_res, output dropped,
		input ready);
	modport sink (input valid, input value_res, input last_res, input dropped,
		output ready);
endinterface

### hw/rtl/mse_ram.sv
// Simple dual-read RAM: one write port, two registered read ports.
module mse_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 64
) (
	input  logic                     clk,
	input  logic                     we,
	input  logic [$clog2(DEPTH)-1:0] wr_addr,
	input  logic [WIDTH-1:0]         wr_data,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_a,
	input  logic [$clog2(DEPTH)-1:0] rd_addr_b,
	output logic [WIDTH-1:0]         rd_data_a,
	output logic [WIDTH-1:0]         rd_data_b
);

	logic [WIDTH-1:0] mem_q [DEPTH];

	always_ff @(posedge clk) begin
		if (we) begin
			mem_q[wr_addr] <= wr_data;
		end
		rd_data_a <= mem_q[rd_addr_a];
		rd_data_b <= mem_q[rd_addr_b];
	end

endmodule

### hw/rtl/merge_sort_engine.sv
// Merge sort engine. Signed 32-bit elements arrive one request at a time on the item
// channel; a request with last set closes the set. Up to MAX_ITEMS elements are kept;
// any further ones are discarded and every result of that set then carries dropped.
// Items are taken back to back while loading. Once the set is closed the engine stops
// accepting items and runs a bottom-up merge sort, passing the data between two RAMs:
// ceil(log2(n)) passes for a set of n elements. Each pass moves one element per cycle,
// a figure set by the loop from the RAM read data through the signed compare and the
// choice of the next read address. Sorted results then stream out in ascending order,
// one per cycle when the sink is ready; equal values keep their arrival order. The
// last result carries last_res. Item requests are accepted again as soon as the last
// result has been placed in the output register, even if it has not been taken.
module merge_sort_engine #(
	parameter int MAX_ITEMS = 64
) (
	input  logic       clk,
	input  logic       arst_n,
	mse_in_if.sink     item,
	mse_out_if.source  result
);
	import mse_pkg::*;

	// Count width holds MAX_ITEMS itself; the run width may reach twice that.
	localparam int CW = $clog2(MAX_ITEMS + 1);
	localparam int AW = $clog2(MAX_ITEMS);
	localparam int WW = CW + 1;
	localparam int SW = CW + 2;

	typedef enum logic [3:0] {
		ST_LOAD  = 4'b0001,
		ST_PRIME = 4'b0010,
		ST_MERGE = 4'b0100,
		ST_EMIT  = 4'b1000
	} state_t;

	state_t          state_q;
	logic [CW-1:0]   cnt_q;
	logic            ovf_q;
	logic            rd_ok_q;
	logic            res_valid_q;
	value_t          res_value_q;
	logic            res_last_q;
	logic            res_drop_q;

	// Sort bookkeeping: set size, run width, merge pointers, output index.
	logic [CW-1:0]   n_q;
	logic [WW-1:0]   width_q;
	logic            src_b_q;
	logic [CW-1:0]   p_q;
	logic [CW-1:0]   q_q;
	logic [CW-1:0]   k_q;
	logic [CW-1:0]   mid_q;
	logic [CW-1:0]   hi_q;
	logic [CW-1:0]   e_q;

	logic            in_acc;
	logic            room;
	logic [CW-1:0]   n_load;
	logic [VALUE_W-1:0] rd0_a, rd1_a, rd0_b, rd1_b;
	value_t          rd_p;
	value_t          rd_q;
	logic            merging;
	logic            p_ok, q_ok, take_q;
	value_t          mg_data;
	logic [CW-1:0]   k_inc;
	logic            group_end, pass_end;
	logic [SW-1:0]   mid_sum, hi_sum, pm_mid_sum, pm_hi_sum;
	logic [CW-1:0]   mid_nx, hi_nx, pm_mid, pm_hi;
	logic [CW-1:0]   p_nx, q_nx;
	logic [WW-1:0]   w2;
	logic            emit_go;
	logic            e_last;
	logic [CW-1:0]   e_nx;
	logic [AW-1:0]   rd_addr_0, rd_addr_1;
	logic            we_a, we_b;
	logic [AW-1:0]   wr_addr_a;
	logic [VALUE_W-1:0] wr_data_a;

	assign item.ready = (state_q == ST_LOAD);
	assign in_acc     = item.valid && item.ready;
	assign room       = (cnt_q < CW'(MAX_ITEMS));
	assign n_load     = cnt_q + CW'(room);

	// Both RAMs are read at the same addresses; the pass parity selects the source.
	assign rd_p = src_b_q ? rd0_b : rd0_a;
	assign rd_q = src_b_q ? rd1_b : rd1_a;

	// Merge step: the heads of the left and right runs are on the read ports.
	assign merging   = (state_q == ST_MERGE);
	assign p_ok      = (p_q < mid_q);
	assign q_ok      = (q_q < hi_q);
	assign take_q    = q_ok && (!p_ok || (rd_q < rd_p));
	assign mg_data   = take_q ? rd_q : rd_p;
	assign k_inc     = k_q + CW'(1);
	assign group_end = (k_inc == hi_q);
	assign pass_end  = (k_inc == n_q);

	// Bounds of the next pair of runs, clipped to the set size.
	assign mid_sum = SW'(hi_q) + SW'(width_q);
	assign hi_sum  = SW'(hi_q) + SW'({width_q, 1'b0});
	assign mid_nx  = (mid_sum > SW'(n_q)) ? n_q : mid_sum[CW-1:0];
	assign hi_nx   = (hi_sum > SW'(n_q)) ? n_q : hi_sum[CW-1:0];

	// Bounds of the first pair of runs of a pass.
	assign pm_mid_sum = SW'(width_q);
	assign pm_hi_sum  = SW'({width_q, 1'b0});
	assign pm_mid     = (pm_mid_sum > SW'(n_q)) ? n_q : pm_mid_sum[CW-1:0];
	assign pm_hi      = (pm_hi_sum > SW'(n_q)) ? n_q : pm_hi_sum[CW-1:0];

	assign p_nx = group_end ? hi_q : (p_q + CW'(!take_q));
	assign q_nx = group_end ? mid_nx : (q_q + CW'(take_q));
	assign w2   = width_q << 1;

	// Output side: the element at e_q sits on read port 0 once rd_ok_q is set.
	assign emit_go = (state_q == ST_EMIT) && rd_ok_q && (!res_valid_q || result.ready);
	assign e_last  = ((e_q + CW'(1)) == n_q);
	assign e_nx    = e_q + CW'(emit_go);

	// Outside loading, the read addresses point at the next head, so the data is on the read ports in the cycle after.
	always_comb begin
		rd_addr_0 = '0;
		rd_addr_1 = '0;
		unique case (state_q)
			ST_LOAD: begin
				rd_addr_0 = '0;
				rd_addr_1 = '0;
			end
			ST_PRIME: begin
				rd_addr_0 = '0;
				rd_addr_1 = pm_mid[AW-1:0];
			end
			ST_MERGE: begin
				rd_addr_0 = p_nx[AW-1:0];
				rd_addr_1 = q_nx[AW-1:0];
			end
			ST_EMIT: begin
				rd_addr_0 = e_nx[AW-1:0];
				rd_addr_1 = '0;
			end
			default: begin
				rd_addr_0 = '0;
				rd_addr_1 = '0;
			end
		endcase
	end

	// Store A takes incoming elements and the second, fourth and later even-numbered
	// passes; store B takes the first, third and later odd-numbered ones.
	assign we_a      = (in_acc && room) || (merging && src_b_q);
	assign wr_addr_a = (state_q == ST_LOAD) ? cnt_q[AW-1:0] : k_q[AW-1:0];
	assign wr_data_a = (state_q == ST_LOAD) ? item.value : mg_data;
	assign we_b      = merging && !src_b_q;

	mse_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_ITEMS)
	) u_store_a (
		.clk       (clk),
		.we        (we_a),
		.wr_addr   (wr_addr_a),
		.wr_data   (wr_data_a),
		.rd_addr_a (rd_addr_0),
		.rd_addr_b (rd_addr_1),
		.rd_data_a (rd0_a),
		.rd_data_b (rd1_a)
	);

	mse_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (MAX_ITEMS)
	) u_store_b (
		.clk       (clk),
		.we        (we_b),
		.wr_addr   (k_q[AW-1:0]),
		.wr_data   (mg_data),
		.rd_addr_a (rd_addr_0),
		.rd_addr_b (rd_addr_1),
		.rd_data_a (rd0_b),
		.rd_data_b (rd1_b)
	);

	// Control state.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= ST_LOAD;
			cnt_q       <= '0;
			ovf_q       <= 1'b0;
			rd_ok_q     <= 1'b0;
			res_valid_q <= 1'b0;
		end else begin
			if (emit_go) begin
				res_valid_q <= 1'b1;
			end else if (result.ready) begin
				res_valid_q <= 1'b0;
			end
			unique case (state_q)
				ST_LOAD: begin
					rd_ok_q <= 1'b0;
					if (in_acc) begin
						cnt_q <= n_load;
						ovf_q <= ovf_q | !room;
						if (item.last) begin
							state_q <= (n_load > CW'(1)) ? ST_PRIME : ST_EMIT;
						end
					end
				end
				ST_PRIME: begin
					state_q <= ST_MERGE;
				end
				ST_MERGE: begin
					rd_ok_q <= 1'b0;
					if (pass_end) begin
						state_q <= (w2 < WW'(n_q)) ? ST_PRIME : ST_EMIT;
					end
				end
				ST_EMIT: begin
					rd_ok_q <= 1'b1;
					if (emit_go && e_last) begin
						state_q <= ST_LOAD;
						cnt_q   <= '0;
						ovf_q   <= 1'b0;
					end
				end
				default: begin
					state_q <= ST_LOAD;
				end
			endcase
		end
	end

	// Sort pointers and the result payload.
	always_ff @(posedge clk) begin
		if (emit_go) begin
			res_value_q <= rd_p;
			res_last_q  <= e_last;
			res_drop_q  <= ovf_q;
		end
		unique case (state_q)
			ST_LOAD: begin
				if (in_acc && item.last) begin
					n_q     <= n_load;
					width_q <= WW'(1);
					src_b_q <= 1'b0;
					e_q     <= '0;
				end
			end
			ST_PRIME: begin
				p_q   <= '0;
				q_q   <= pm_mid;
				mid_q <= pm_mid;
				hi_q  <= pm_hi;
				k_q   <= '0;
			end
			ST_MERGE: begin
				k_q <= k_inc;
				if (pass_end) begin
					src_b_q <= !src_b_q;
					width_q <= w2;
					e_q     <= '0;
				end else begin
					p_q <= p_nx;
					q_q <= q_nx;
					if (group_end) begin
						mid_q <= mid_nx;
						hi_q  <= hi_nx;
					end
				end
			end
			ST_EMIT: begin
				e_q <= e_nx;
			end
			default: begin
				e_q <= '0;
			end
		endcase
	end

	assign result.valid     = res_valid_q;
	assign result.value_res = res_value_q;
	assign result.last_res  = res_last_q;
	assign result.dropped   = res_drop_q;

endmodule

### hw/rtl/mse_checker.sv
// Port-level checks on the merge sort engine.
module mse_checker (
	input logic       clk,
	input logic       arst_n,
	mse_in_if.sink    item,
	mse_out_if.source result
);
	import mse_pkg::*;

	logic   out_acc;
	logic   open_q;
	value_t prev_val_q;
	logic   prev_drop_q;

	assign out_acc = result.valid && result.ready;

	// Remembers the previous result of the set that is still being delivered.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			open_q      <= 1'b0;
			prev_val_q  <= '0;
			prev_drop_q <= 1'b0;
		end else if (out_acc) begin
			open_q      <= !result.last_res;
			prev_val_q  <= result.value_res;
			prev_drop_q <= result.dropped;
		end
	end

	a_result_hold: assert property (@(posedge clk) disable iff (!arst_n)
		result.valid && !result.ready |=> result.valid && $stable(result.value_res)
			&& $stable(result.last_res) && $stable(result.dropped))
		else $error("result request changed while stalled");

	a_ready_falls_on_last: assert property (@(posedge clk) disable iff (!arst_n)
		$fell(item.ready) |-> $past(item.valid && item.ready && item.last))
		else $error("item ready dropped without a closing element");

	a_ascending: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && open_q |-> (result.value_res >= prev_val_q))
		else $error("results of a set are not in ascending order");

	a_dropped_steady: assert property (@(posedge clk) disable iff (!arst_n)
		out_acc && open_q |-> (result.dropped == prev_drop_q))
		else $error("dropped flag changed within a set");

endmodule

bind merge_sort_engine mse_checker u_mse_checker (
	.clk    (clk),
	.arst_n (arst_n),
	.item   (item),
	.result (result)
);

### sim/testbench.sv
`timescale 1ns / 1ps

// Self-checking bench for the merge sort engine.
//
// Requests carry signed elements into the engine; a request with last set closes the
// set. A behavioural sorter below keeps its own copy of the open set, applies the same
// capacity rule and, on every closing request, queues the sorted results that the
// engine has to return. The result side pops and compares one result per handshake.
module testbench;
	import mse_pkg::*;

	localparam int MAX_ITEMS     = 64;
	localparam int CYCLE_LIMIT   = 200000;
	localparam int HOLD_CYCLES   = 700;
	localparam int SETTLE_CYCLES = 100;

	// One sorted element as it should leave the engine.
	typedef struct {
		value_t value;
		logic   last;
		logic   dropped;
	} sorted_elem_t;

	// One row of the directed table. Where typed is set, the row closes a set of a
	// single element, so the result is that element alone with no drop flag.
	typedef struct {
		value_t value;
		bit     last;
		bit     typed;
		value_t want;
	} stim_row_t;

	localparam value_t MOST_NEG = 32'sh8000_0000;
	localparam value_t MOST_POS = 32'sh7fff_ffff;

	logic clk;
	logic arst_n;

	mse_in_if  item_bus ();
	mse_out_if result_bus ();

	merge_sort_engine #(
		.MAX_ITEMS(MAX_ITEMS)
	) dut (
		.clk   (clk),
		.arst_n(arst_n),
		.item  (item_bus),
		.result(result_bus)
	);

	// Results that the engine still owes, oldest first.
	sorted_elem_t sorted_due [$];

	// The sorter's own view of the set currently being collected.
	value_t open_set [$];
	bit     open_dropped = 1'b0;

	int failures      = 0;
	int results_seen  = 0;
	int requests_sent = 0;
	int sets_closed   = 0;
	int overflow_sets = 0;
	int cycle_count   = 0;

	// Idling controls: the sender's are read by the main sequence only, the
	// receiver's by the result process.
	int   tx_idle_pct  = 0;
	int   rx_stall_pct = 0;
	logic rx_hold      = 1'b0;
	event long_hold;

	// Directed sets. The first three are single elements, two at the extremes, straight
	// after reset. Then a pair out of order, a descending set with a repeated value,
	// an even set whose runs no longer pair up evenly after the first pass, and an equal
	// pair.
	stim_row_t directed_rows [17] = '{
		'{MOST_NEG, 1'b1, 1'b1, MOST_NEG},
		'{MOST_POS, 1'b1, 1'b1, MOST_POS},
		'{-32'sd1,  1'b1, 1'b1, -32'sd1},
		'{32'sd5,   1'b0, 1'b0, '0},
		'{-32'sd3,  1'b1, 1'b0, '0},
		'{MOST_POS, 1'b0, 1'b0, '0},
		'{-32'sd1,  1'b0, 1'b0, '0},
		'{-32'sd1,  1'b0, 1'b0, '0},
		'{MOST_NEG, 1'b1, 1'b0, '0},
		'{32'sd1,   1'b0, 1'b0, '0},
		'{MOST_NEG, 1'b0, 1'b0, '0},
		'{32'sd7,   1'b0, 1'b0, '0},
		'{32'sd7,   1'b0, 1'b0, '0},
		'{32'sd0,   1'b0, 1'b0, '0},
		'{-32'sd7,  1'b1, 1'b0, '0},
		'{32'sd3,   1'b0, 1'b0, '0},
		'{32'sd3,   1'b1, 1'b0, '0}
	};

	initial begin
		clk = 1'b0;
		forever #1 clk = ~clk;
	end

	// Watchdog: ends the run as a failure if it reaches CYCLE_LIMIT.
	initial begin
		while (cycle_count < CYCLE_LIMIT) begin
			@(posedge clk);
			cycle_count++;
		end
		$display("Timed out after %0d cycles with %0d results outstanding.",
			cycle_count, sorted_due.size());
		$display("CHECK FAILED");
		$finish;
	end

	// Stores one accepted element and, when it closes the set, sorts the set
	// bottom-up exactly as the engine does: runs of width 1, 2, 4 and so on are
	// merged pairwise, with the left run winning ties.
	function automatic void predict_request(input value_t v, input bit closes);
		value_t src [MAX_ITEMS];
		value_t dst [MAX_ITEMS];
		int     n;
		int     width;
		int     lo;
		int     mid;
		int     hi;
		int     p;
		int     q;

		if (open_set.size() < MAX_ITEMS)
			open_set.push_back(v);
		else
			open_dropped = 1'b1;

		if (closes) begin
			n = open_set.size();
			for (int k = 0; k < n; k++)
				src[k] = open_set[k];
			for (width = 1; width < n; width *= 2) begin
				for (lo = 0; lo < n; lo = hi) begin
					mid = (lo + width < n) ? lo + width : n;
					hi  = (lo + 2 * width < n) ? lo + 2 * width : n;
					p   = lo;
					q   = mid;
					for (int k = lo; k < hi; k++) begin
						// The right run goes first only when strictly smaller.
						if (q < hi && (p >= mid || src[q] < src[p])) begin
							dst[k] = src[q];
							q++;
						end else begin
							dst[k] = src[p];
							p++;
						end
					end
				end
				src = dst;
			end
			for (int k = 0; k < n; k++)
				sorted_due.push_back('{src[k], logic'(k == n - 1), logic'(open_dropped)});
			sets_closed++;
			if (open_dropped)
				overflow_sets++;
			open_set.delete();
			open_dropped = 1'b0;
		end
	endfunction

	// Offers one request and returns at the edge at which it is accepted. A random
	// gap may come first; back-to-back requests keep valid high throughout.
	task automatic send_request(input value_t v, input bit closes);
		while ($urandom_range(0, 99) < tx_idle_pct) begin
			item_bus.valid <= 1'b0;
			@(posedge clk);
		end
		item_bus.valid <= 1'b1;
		item_bus.value <= v;
		item_bus.last  <= closes;
		@(posedge clk);
		while (!item_bus.ready)
			@(posedge clk);
		requests_sent++;
	endtask

	// A narrow spread packs a set with repeated values; a wide one rarely repeats.
	function automatic value_t random_value(input int spread);
		case ($urandom_range(0, 7)) inside
			0: return MOST_NEG;
			1: return MOST_POS;
			[2:3]: return value_t'(int'($urandom_range(0, spread)) - spread / 2);
			default: return value_t'($urandom);
		endcase
	endfunction

	task automatic send_set(input int size);
		int     spread;
		value_t v;

		spread = $urandom_range(0, 1) ? 6 : 1000;
		for (int k = 0; k < size; k++) begin
			v = random_value(spread);
			send_request(v, k == size - 1);
			predict_request(v, k == size - 1);
		end
	endtask

	// The sender stands still until every owed result has come back.
	task automatic wait_drained();
		item_bus.valid <= 1'b0;
		while (sorted_due.size() != 0)
			@(posedge clk);
	endtask

	// One idling phase: a set of the given size first, then small sets of random
	// size until the budget of further requests is used up.
	task automatic run_phase(input int tx_pct, input int rx_pct, input int first_size,
		input int budget);
		int size;
		int left;

		tx_idle_pct = tx_pct;
		rx_stall_pct <= rx_pct;
		send_set(first_size);
		left = budget;
		while (left > 0) begin
			size = $urandom_range(1, 12);
			if (size > left)
				size = left;
			send_set(size);
			left -= size;
		end
		wait_drained();
	endtask

	// Long receiver hold-off. While it lasts the engine fills, sorts and then sits
	// on its first result, and the sender keeps offering the next set's requests.
	initial begin
		forever begin
			@(long_hold);
			rx_hold <= 1'b1;
			repeat (HOLD_CYCLES) @(posedge clk);
			rx_hold <= 1'b0;
		end
	end

	// Result side: every handshake is checked against the oldest owed result, and a
	// result with nothing owed is a failure in its own right.
	task automatic check_result();
		sorted_elem_t want;

		results_seen++;
		if (sorted_due.size() == 0) begin
			$error("result with nothing expected: value_res %0d, last_res %0b, dropped %0b",
				result_bus.value_res, result_bus.last_res, result_bus.dropped);
			failures++;
		end else begin
			want = sorted_due.pop_front();
			if (result_bus.value_res !== want.value) begin
				$error("value_res: expected %0d, got %0d", want.value, result_bus.value_res);
				failures++;
			end
			if (result_bus.last_res !== want.last) begin
				$error("last_res: expected %0b, got %0b", want.last, result_bus.last_res);
				failures++;
			end
			if (result_bus.dropped !== want.dropped) begin
				$error("dropped: expected %0b, got %0b", want.dropped, result_bus.dropped);
				failures++;
			end
		end
	endtask

	always @(posedge clk) begin
		if (arst_n && result_bus.valid && result_bus.ready)
			check_result();
		result_bus.ready <= !rx_hold && ($urandom_range(0, 99) >= rx_stall_pct);
	end

	initial begin
		arst_n           = 1'b0;
		item_bus.valid   = 1'b0;
		item_bus.value   = '0;
		item_bus.last    = 1'b0;
		repeat (6) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// Directed table. Typed rows are whole sets of one element, so their result
		// is written out here; the other rows go through the sorter.
		foreach (directed_rows[row]) begin
			send_request(directed_rows[row].value, directed_rows[row].last);
			if (directed_rows[row].typed) begin
				sorted_due.push_back('{directed_rows[row].want, 1'b1, 1'b0});
				sets_closed++;
			end else begin
				predict_request(directed_rows[row].value, directed_rows[row].last);
			end
		end
		wait_drained();

		// No idling, but a long receiver hold-off over a full set of MAX_ITEMS.
		-> long_hold;
		run_phase(0, 0, MAX_ITEMS, 16);
		// Sender idling; two elements too many, so the closing value is lost as well.
		run_phase(46, 0, MAX_ITEMS + 2, 16);
		// Receiver stalling; exactly the closing value is one too many.
		run_phase(0, 46, MAX_ITEMS + 1, 16);
		// Both sides idle, then a long run of small sets.
		run_phase(29, 29, 2, 20);

		wait_drained();
		repeat (SETTLE_CYCLES) @(posedge clk);

		$display("Sorted %0d sets from %0d requests, %0d of them over capacity;",
			sets_closed, requests_sent, overflow_sets);
		$display("%0d results checked.", results_seen);
		$display("Idling covered: none, sender only, receiver only, both, plus one long hold-off.");
		if (failures == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule
